// ===== rtl/keyed_line_field_extractor_top_defines.svh =====
// ----------------------------------------------------------------------------
// Keyed line field extractor: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_LINE_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define KEYED_LINE_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication
`define KLFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KLFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/klfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor package
// Shared constants, codes and the byte class record passed front to back.
// ----------------------------------------------------------------------------
package klfe_pkg;

    localparam int MAX_KEY_BYTES  = 32;
    localparam int KEY_IDX_W      = $clog2(MAX_KEY_BYTES);
    localparam int KLEN_W         = $clog2(MAX_KEY_BYTES + 1);
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 3;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam int MAG_W          = 16;
    localparam logic [MAG_W-1:0] MAG_SAT   = 16'h8000;
    localparam logic [15:0]      VALUE_MAX = 16'h7FFF;
    localparam logic [15:0]      VALUE_MIN = 16'h8000;
    localparam logic [1:0]       FIELD_TARGET = 2'd3;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_LENGTH  = 3'd0,
        CFG_KEY_BYTES_A = 3'd1,
        CFG_KEY_BYTES_B = 3'd2,
        CFG_KEY_BYTES_C = 3'd3,
        CFG_KEY_BYTES_D = 3'd4
    } cfg_index_t;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // one classified text byte
    typedef struct packed {
        logic                     last;
        logic                     is_zero;
        logic                     is_newline;
        logic                     is_comma;
        logic                     is_space;
        logic                     is_digit;
        logic                     is_plus;
        logic                     is_minus;
        logic [3:0]               digit;
        logic [MAX_KEY_BYTES-1:0] key_hit;
    } klfe_class_t;

endpackage

// ===== rtl/klfe_if.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor channels
// Valid/ready channels for text bytes in and results out.
// ----------------------------------------------------------------------------
interface klfe_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_buffer;

    modport source (output valid, output text_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

interface klfe_result_if;
    logic               valid;
    logic               ready;
    logic               key_found;
    logic signed [15:0] field_value;

    modport source (output valid, output key_found, output field_value, input ready);
    modport sink   (input valid, input key_found, input field_value, output ready);
endinterface

// ===== rtl/keyed_line_field_extractor_top.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor
// Finds the first text line holding a key and returns its third comma field.
// ----------------------------------------------------------------------------
// Text bytes stream in on text_in, one request per byte, and the block takes
// one byte every clock cycle for as long as results are collected. Lines end
// at newline; the first non-empty line that contains the key (up to 32 bytes,
// length 0 matches any line) supplies the third non-empty comma field, read
// like atoi and saturated to 16 bits signed. A zero byte ends the text. The
// byte flagged end_of_buffer produces exactly one request on result_out,
// valid once the back end has popped that byte and loaded its output
// register; then the block is clean for the next buffer. The front end
// compares each byte against all key bytes in parallel and the back end
// folds that into a shift-and prefix vector. A four-entry queue sits
// between them: the front keeps taking bytes while a finished result waits
// in the output register. If result_out is held off, the back end stops at
// the next buffer's final byte, and the front stalls once three more bytes
// have queued behind that byte.
// Key registers are written through cfg_write_en/cfg_index/cfg_data, with
// index 0 the key length and 1..4 the key bytes packed eight to a word,
// little-endian; write them only while no buffer is in flight.
// ----------------------------------------------------------------------------
module keyed_line_field_extractor_top
    import klfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    klfe_text_if.sink              text_in,
    klfe_result_if.source          result_out
);

    // front end to queue
    logic              push_valid;
    logic              push_ready;
    klfe_class_t       push_class;

    // queue to back end
    logic              pop_valid;
    logic              pop_ready;
    klfe_class_t       pop_class;

    // clamped key length; the user must keep it static while a buffer is in flight, the block does not enforce it
    logic [KLEN_W-1:0] key_len;

    klfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_in      (text_in),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_class   (push_class),
        .key_len      (key_len)
    );

    klfe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_class (push_class),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_class  (pop_class)
    );

    klfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_class  (pop_class),
        .key_len    (key_len),
        .result_out (result_out)
    );

endmodule

// ===== rtl/klfe_front.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor: front end
// Holds the key registers and classifies each incoming byte.
// ----------------------------------------------------------------------------
module klfe_front
    import klfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    klfe_text_if.sink              text_in,
    output logic                   push_valid,
    input  logic                   push_ready,
    output klfe_class_t            push_class,
    output logic [KLEN_W-1:0]      key_len
);

    logic [KLEN_W-1:0]          key_length_reg;
    logic [MAX_KEY_BYTES*8-1:0] key_bytes_reg;
    logic [7:0]                 ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            key_bytes_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_KEY_LENGTH:  key_length_reg <= cfg_data[KLEN_W-1:0];
                CFG_KEY_BYTES_A: key_bytes_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_KEY_BYTES_B: key_bytes_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_KEY_BYTES_C: key_bytes_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_KEY_BYTES_D: key_bytes_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                default: ;
            endcase
        end
    end

    // lengths past the key store clamp to its size
    assign key_len = (key_length_reg > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES)
                                                               : key_length_reg;

    assign ch             = text_in.text_byte;
    assign push_valid     = text_in.valid;
    assign text_in.ready  = push_ready;

    always_comb
    begin
        push_class.last       = text_in.end_of_buffer;
        push_class.is_zero    = (ch == CHAR_NUL);
        push_class.is_newline = (ch == CHAR_NL);
        push_class.is_comma   = (ch == CHAR_COMMA);
        push_class.is_space   = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
        push_class.is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        push_class.is_plus    = (ch == CHAR_PLUS);
        push_class.is_minus   = (ch == CHAR_MINUS);
        push_class.digit      = ch[3:0];
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            push_class.key_hit[i] = (ch == key_bytes_reg[8*i +: 8]);
        end
    end

endmodule

// ===== rtl/klfe_fifo.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor: class queue
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module klfe_fifo
    import klfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  klfe_class_t push_class,
    output logic        pop_valid,
    input  logic        pop_ready,
    output klfe_class_t pop_class
);

    klfe_class_t           slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_class  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_class;
        end
    end

endmodule

// ===== rtl/klfe_back.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor: back end
// Line, key and number tracking per byte; holds the result register.
// ----------------------------------------------------------------------------
module klfe_back
    import klfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  klfe_class_t       pop_class,
    input  logic [KLEN_W-1:0] key_len,
    klfe_result_if.source     result_out
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    // shift-and prefix matches: bit i means key bytes 0..i end at this byte
    logic [MAX_KEY_BYTES-1:0] prefix_reg, prefix_next, prefix_shift;
    logic                     seen_reg, seen_next;
    logic [1:0]               fields_reg, fields_next;
    logic                     in_field_reg, in_field_next;
    phase_t                   phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     latched_reg, latched_next;
    logic [15:0]              answer_reg, answer_next;
    logic                     ended_reg, ended_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    logic [15:0]              out_value_reg, out_value_next;

    logic                     pop;
    logic                     active;
    logic                     end_req;
    logic                     run_digits;
    logic                     key_match;
    logic [KLEN_W-1:0]        klen_m1;
    logic [MAG_W+3:0]         mag_x10;
    logic [MAG_W-1:0]         mag_acc;
    logic [15:0]              line_value;

    assign pop_ready = !pop_class.last || !out_valid_reg || result_out.ready;
    assign pop       = pop_valid && pop_ready;
    assign active    = !ended_reg && !latched_reg;

    assign prefix_shift = {prefix_reg[MAX_KEY_BYTES-2:0], 1'b1} & pop_class.key_hit;
    assign klen_m1      = key_len - KLEN_W'(1);
    assign key_match    = (key_len == '0) || prefix_shift[klen_m1[KEY_IDX_W-1:0]];

    assign mag_x10 = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                   + {{(MAG_W){1'b0}}, pop_class.digit};
    assign mag_acc = (mag_x10 > {4'b0, MAG_SAT}) ? MAG_SAT : mag_x10[MAG_W-1:0];

    always_comb
    begin
        prefix_next    = prefix_reg;
        seen_next      = seen_reg;
        fields_next    = fields_reg;
        in_field_next  = in_field_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        latched_next   = latched_reg;
        answer_next    = answer_reg;
        ended_next     = ended_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        end_req        = 1'b0;
        run_digits     = 1'b0;
        line_value     = '0;

        if (pop)
        begin
            if (active)
            begin
                if (pop_class.is_zero)
                begin
                    end_req    = 1'b1;
                    ended_next = 1'b1;
                end
                else if (pop_class.is_newline)
                begin
                    end_req = 1'b1;
                end
                else
                begin
                    if (pop_class.is_comma)
                    begin
                        if (in_field_reg && (fields_reg == FIELD_TARGET))
                        begin
                            phase_next = PH_STOP;
                        end
                        in_field_next = 1'b0;
                    end
                    else
                    begin
                        if (!in_field_reg)
                        begin
                            in_field_next = 1'b1;
                            if (fields_reg != FIELD_TARGET)
                            begin
                                fields_next = fields_reg + 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        if (fields_next == FIELD_TARGET)
                        begin
                            unique case (phase_next)
                                PH_SKIP:
                                begin
                                    if (pop_class.is_space)
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                    else if (pop_class.is_plus || pop_class.is_minus)
                                    begin
                                        neg_next   = pop_class.is_minus;
                                        phase_next = PH_DIGITS;
                                    end
                                    else if (pop_class.is_digit)
                                    begin
                                        phase_next = PH_DIGITS;
                                        run_digits = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_STOP;
                                    end
                                end
                                PH_DIGITS: run_digits = 1'b1;
                                default:   run_digits = 1'b0;
                            endcase
                            if (run_digits)
                            begin
                                if (pop_class.is_digit)
                                begin
                                    mag_next = mag_acc;
                                end
                                else
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                        end
                    end
                    prefix_next = prefix_shift;
                    if (!seen_reg)
                    begin
                        seen_next = key_match;
                    end
                end
            end

            if (pop_class.last)
            begin
                end_req = 1'b1;
            end

            if (end_req)
            begin
                if (fields_next == FIELD_TARGET)
                begin
                    if (neg_next)
                    begin
                        line_value = (mag_next >= MAG_SAT) ? VALUE_MIN : (16'd0 - mag_next);
                    end
                    else
                    begin
                        line_value = (mag_next > VALUE_MAX) ? VALUE_MAX : mag_next;
                    end
                end
                if (seen_next && !latched_next)
                begin
                    latched_next = 1'b1;
                    answer_next  = line_value;
                end
                prefix_next   = '0;
                seen_next     = 1'b0;
                fields_next   = '0;
                in_field_next = 1'b0;
                phase_next    = PH_SKIP;
                neg_next      = 1'b0;
                mag_next      = '0;
            end

            if (pop_class.last)
            begin
                out_valid_next = 1'b1;
                out_found_next = latched_next;
                out_value_next = latched_next ? answer_next : 16'd0;
                latched_next   = 1'b0;
                answer_next    = '0;
                ended_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            seen_reg      <= 1'b0;
            fields_reg    <= '0;
            in_field_reg  <= 1'b0;
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            latched_reg   <= 1'b0;
            answer_reg    <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            prefix_reg    <= prefix_next;
            seen_reg      <= seen_next;
            fields_reg    <= fields_next;
            in_field_reg  <= in_field_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            latched_reg   <= latched_next;
            answer_reg    <= answer_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_value_reg <= out_value_next;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.key_found   = out_found_reg;
    assign result_out.field_value = out_value_reg;

endmodule

// ===== rtl/klfe_checker.sv =====
// ----------------------------------------------------------------------------
// Keyed line field extractor: port checker
// Watches the top-level ports; bound onto the top level.
// ----------------------------------------------------------------------------
`include "keyed_line_field_extractor_top_defines.svh"

module klfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        key_found,
    input logic [15:0] field_value
);

    // buffers closed on the input side but not yet answered
    logic [3:0] open_reg, open_next;
    logic       in_last_acc;
    logic       out_acc;

    assign in_last_acc = in_valid && in_ready && in_last;
    assign out_acc     = out_valid && out_ready;
    assign open_next   = open_reg + 4'(in_last_acc) - 4'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `KLFE_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(key_found) && $stable(field_value), "stalled result changed")
    `KLFE_ASSERT_NOW(a_no_key_zero, out_valid && !key_found, field_value == 16'd0, "value without key match")
    `KLFE_ASSERT_NOW(a_result_has_buffer, out_valid, open_reg != 4'd0, "result without a closed buffer")

endmodule

bind keyed_line_field_extractor_top klfe_checker u_klfe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (text_in.valid),
    .in_ready    (text_in.ready),
    .in_last     (text_in.end_of_buffer),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .key_found   (result_out.key_found),
    .field_value (result_out.field_value)
);
